// File: sv/dma_slot_ownership_tracker_assert.svh
// Assertion macros used by the tracker engine module.
// Each expects clk and arst_n in scope.
`ifndef DMA_SLOT_OWNERSHIP_TRACKER_ASSERT_SVH
`define DMA_SLOT_OWNERSHIP_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define DSOT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dsot check failed");

// Next-cycle implication.
`define DSOT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dsot check failed");

`endif

// File: sv/dsot_pkg.sv
package dsot_pkg;

	localparam int FUNC_W      = 3;
	localparam int STATUS_W    = 3;
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 304;
	localparam int CNT_NUM     = 6;

	localparam int CNT_COMPLETE = 0;
	localparam int CNT_STALE    = 1;
	localparam int CNT_ERROR    = 2;
	localparam int CNT_TIMEOUT  = 3;
	localparam int CNT_FULL     = 4;
	localparam int CNT_FAULT    = 5;

	typedef enum logic [FUNC_W-1:0] {
		FN_SUBMIT     = 3'd0,
		FN_COMPLETE   = 3'd1,
		FN_TIMEOUT    = 3'd2,
		FN_DMA_ERR    = 3'd3,
		FN_FIN_STOP   = 3'd4,
		FN_BEGIN_READ = 3'd5,
		FN_FIN_READ   = 3'd6,
		FN_STOP       = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		PH_FREE     = 3'd0,
		PH_QUEUED   = 3'd1,
		PH_READY    = 3'd2,
		PH_READING  = 3'd3,
		PH_STOPPING = 3'd4
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_NO_SLOT  = 3'd1,
		ST_STALE    = 3'd2,
		ST_INVALID  = 3'd3,
		ST_NO_READY = 3'd4
	} status_t;

	typedef struct packed {
		phase_t      phase;
		logic [63:0] seq;
		logic [31:0] cookie;
	} slot_entry_t;

	typedef struct packed {
		logic complete;
		logic stale;
		logic error;
		logic timeout;
		logic full;
		logic fault;
		logic ready_inc;
		logic ready_dec;
	} cnt_evt_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  slot;
		logic [63:0] seq;
		logic [31:0] cookie;
	} result_t;

endpackage

// File: sv/dma_slot_ownership_tracker.sv
// Targeted ops (complete, stops, finish read) read their slot in S_RD, check it in S_CHECK and
// wait in S_DONE until the output register takes the result. Submit / begin read scan the slot
// memory lowest first, one read per cycle, ending on a hit or once every slot has been read.
// Throughput: one op at a time; the next beat is taken once the result is in the output
// register. A single memory read port serves both the targeted reads and the scan.
// Reset (arst_n low): all slots free (per-slot valid bits clear at once), counters zero.
module dma_slot_ownership_tracker #(
	parameter int SLOT_COUNT = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [7:0] slot_sel, [71:8] seq_tag, [103:72] cookie_tag, [104] copy_ok, rest zero
	input  logic [dsot_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// [2:0] func
	input  logic [dsot_pkg::FUNC_W-1:0]          s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [7:0] granted_slot, [71:8] granted_seq, [103:72] granted_cookie, [104] readable,
	// [136:105] completions, [168:137] stale_events, [200:169] error_events,
	// [232:201] timeout_events, [264:233] full_events, [296:265] fault_events, rest zero
	output logic [dsot_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// [2:0] status
	output logic [dsot_pkg::STATUS_W-1:0]        m_axis_tuser
);
	import dsot_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int PAD_W = OUT_TDATA_W - (8 + 64 + 32 + 1 + CNT_NUM * 32);

	logic                      start;
	logic                      eng_idle;
	logic                      res_valid;
	logic                      res_take;
	result_t                   res;
	logic                      rd_en;
	logic [IDX_W-1:0]          rd_addr;
	slot_entry_t               rd_entry;
	logic                      wr_en;
	logic [IDX_W-1:0]          wr_addr;
	slot_entry_t               wr_entry;
	cnt_evt_t                  evt;
	logic [CNT_NUM-1:0][31:0]  cnt;
	logic                      readable;

	// output register
	logic                      m_valid_q;
	logic [OUT_TDATA_W-1:0]    m_tdata_q;
	logic [STATUS_W-1:0]       m_tuser_q;

	// input beat is taken whenever the engine is free, even with a result still pending
	assign s_axis_tready = eng_idle;
	assign start         = s_axis_tvalid && eng_idle;

	// engine hands over its result as soon as the output register is empty or draining
	assign res_take = res_valid && (!m_valid_q || m_axis_tready);

	dsot_slot_ram #(
		.SLOT_COUNT(SLOT_COUNT),
		.IDX_W     (IDX_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_entry(rd_entry),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_entry(wr_entry)
	);

	dsot_event_cnt #(
		.CNT_W     (CNT_W)
	) u_cnt (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt),
		.cnt     (cnt),
		.readable(readable)
	);

	dsot_engine #(
		.SLOT_COUNT(SLOT_COUNT),
		.IDX_W     (IDX_W),
		.CNT_W     (CNT_W)
	) u_eng (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.func      (func_t'(s_axis_tuser)),
		.slot_sel  (s_axis_tdata[7:0]),
		.seq_tag   (s_axis_tdata[71:8]),
		.cookie_tag(s_axis_tdata[103:72]),
		.copy_ok   (s_axis_tdata[104]),
		.idle      (eng_idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_entry  (rd_entry),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_entry  (wr_entry),
		.evt       (evt)
	);

	// counters and readable already reflect this op when the engine sits in its done state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= '0;
		end else begin
			if (res_take) begin
				m_valid_q <= 1'b1;
				m_tdata_q <= {PAD_W'(0), cnt, readable, res.cookie, res.seq, res.slot};
				m_tuser_q <= res.status;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule

// File: sv/dsot_slot_ram.sv
module dsot_slot_ram #(
	parameter int SLOT_COUNT = 8,
	parameter int IDX_W      = 3
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [IDX_W-1:0]          rd_addr,
	output dsot_pkg::slot_entry_t     rd_entry,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_addr,
	input  dsot_pkg::slot_entry_t     wr_entry
);
	import dsot_pkg::*;

	slot_entry_t             mem_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0]   vld_q;
	slot_entry_t             rdata_s1;
	logic                    rvld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	// never-written entries read back as free with zero tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_entry = rvld_s1 ? rdata_s1 :
		slot_entry_t'{phase: PH_FREE, seq: '0, cookie: '0};

endmodule

// File: sv/dsot_event_cnt.sv
module dsot_event_cnt #(
	parameter int CNT_W      = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dsot_pkg::cnt_evt_t                    evt,
	output logic [dsot_pkg::CNT_NUM-1:0][31:0]    cnt,
	output logic                                  readable
);
	import dsot_pkg::*;

	logic [CNT_NUM-1:0][31:0] cnt_q;
	logic [CNT_W-1:0]         ready_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			ready_total_q <= '0;
		end else begin
			if (evt.complete) cnt_q[CNT_COMPLETE] <= cnt_q[CNT_COMPLETE] + 32'd1;
			if (evt.stale)    cnt_q[CNT_STALE]    <= cnt_q[CNT_STALE] + 32'd1;
			if (evt.error)    cnt_q[CNT_ERROR]    <= cnt_q[CNT_ERROR] + 32'd1;
			if (evt.timeout)  cnt_q[CNT_TIMEOUT]  <= cnt_q[CNT_TIMEOUT] + 32'd1;
			if (evt.full)     cnt_q[CNT_FULL]     <= cnt_q[CNT_FULL] + 32'd1;
			if (evt.fault)    cnt_q[CNT_FAULT]    <= cnt_q[CNT_FAULT] + 32'd1;
			// ready count never exceeds the slot count
			if (evt.ready_inc) begin
				ready_total_q <= ready_total_q + CNT_W'(1);
			end else if (evt.ready_dec) begin
				ready_total_q <= ready_total_q - CNT_W'(1);
			end
		end
	end

	assign cnt      = cnt_q;
	assign readable = (ready_total_q != '0);

endmodule

// File: sv/dsot_engine.sv
`include "dma_slot_ownership_tracker_assert.svh"

module dsot_engine #(
	parameter int SLOT_COUNT = 8,
	parameter int IDX_W      = 3,
	parameter int CNT_W      = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  dsot_pkg::func_t        func,
	input  logic [7:0]             slot_sel,
	input  logic [63:0]            seq_tag,
	input  logic [31:0]            cookie_tag,
	input  logic                   copy_ok,
	output logic                   idle,
	output logic                   res_valid,
	input  logic                   res_take,
	output dsot_pkg::result_t      res,
	output logic                   rd_en,
	output logic [IDX_W-1:0]       rd_addr,
	input  dsot_pkg::slot_entry_t  rd_entry,
	output logic                   wr_en,
	output logic [IDX_W-1:0]       wr_addr,
	output dsot_pkg::slot_entry_t  wr_entry,
	output dsot_pkg::cnt_evt_t     evt
);
	import dsot_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CHECK,
		S_SCAN,
		S_DONE
	} state_t;

	state_t            state_q;
	func_t             func_q;
	logic [7:0]        sel_q;
	logic [63:0]       seq_q;
	logic [31:0]       cookie_q;
	logic              copy_ok_q;
	logic [63:0]       last_seq_q;
	logic [CNT_W-1:0]  iss_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  chk_idx_s1;
	result_t           res_q;

	result_t           res_d;
	logic              fin;
	logic              hit;
	logic              sel_ok;
	logic              tags_ok;
	logic              exhausted;
	phase_t            scan_tgt;
	logic [63:0]       nxt_seq;

	assign sel_ok    = (sel_q < 8'(SLOT_COUNT));
	assign tags_ok   = (rd_entry.seq == seq_q) && (rd_entry.cookie == cookie_q);
	assign exhausted = (iss_q == CNT_W'(SLOT_COUNT));
	assign scan_tgt  = (func_q == FN_SUBMIT) ? PH_FREE : PH_READY;
	assign nxt_seq   = last_seq_q + 64'd1;

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = sel_q[IDX_W-1:0];
		wr_entry = rd_entry;
		evt      = '0;
		res_d    = '{status: ST_OK, slot: '0, seq: '0, cookie: '0};
		fin      = 1'b0;
		hit      = 1'b0;
		unique case (state_q)
			S_RD: begin
				rd_en   = sel_ok;
				rd_addr = sel_q[IDX_W-1:0];
			end
			S_CHECK: begin
				fin = 1'b1;
				unique case (func_q)
					FN_COMPLETE: begin
						if (sel_ok && rd_entry.phase == PH_QUEUED && tags_ok) begin
							wr_en          = 1'b1;
							wr_entry.phase = PH_READY;
							evt.complete   = 1'b1;
							evt.ready_inc  = 1'b1;
						end else begin
							res_d.status = ST_STALE;
							evt.stale    = 1'b1;
						end
					end
					FN_TIMEOUT, FN_DMA_ERR, FN_STOP: begin
						if (sel_ok && rd_entry.phase == PH_QUEUED && tags_ok) begin
							wr_en          = 1'b1;
							wr_entry.phase = PH_STOPPING;
							evt.timeout    = (func_q == FN_TIMEOUT);
							evt.error      = (func_q == FN_DMA_ERR);
						end else begin
							res_d.status = ST_INVALID;
						end
					end
					FN_FIN_STOP: begin
						if (sel_ok && rd_entry.phase == PH_STOPPING && tags_ok) begin
							wr_en          = 1'b1;
							wr_entry.phase = PH_FREE;
						end else begin
							res_d.status = ST_INVALID;
						end
					end
					FN_FIN_READ: begin
						// tags are not checked on finish read
						if (sel_ok && rd_entry.phase == PH_READING) begin
							wr_en = 1'b1;
							if (copy_ok_q) begin
								wr_entry.phase = PH_FREE;
							end else begin
								wr_entry.phase = PH_READY;
								evt.ready_inc  = 1'b1;
								evt.fault      = 1'b1;
							end
						end else begin
							res_d.status = ST_INVALID;
						end
					end
					FN_SUBMIT, FN_BEGIN_READ: begin
					end
				endcase
			end
			S_SCAN: begin
				wr_addr = chk_idx_s1;
				if (pend_s1 && rd_entry.phase == scan_tgt) begin
					hit        = 1'b1;
					fin        = 1'b1;
					wr_en      = 1'b1;
					res_d.slot = 8'(chk_idx_s1);
					if (func_q == FN_SUBMIT) begin
						wr_entry     = '{phase: PH_QUEUED, seq: nxt_seq, cookie: cookie_q};
						res_d.seq    = nxt_seq;
						res_d.cookie = cookie_q;
					end else begin
						wr_entry.phase = PH_READING;
						res_d.seq      = rd_entry.seq;
						evt.ready_dec  = 1'b1;
					end
				end else if (!pend_s1 && exhausted) begin
					fin = 1'b1;
					if (func_q == FN_SUBMIT) begin
						res_d.status = ST_NO_SLOT;
						evt.full     = 1'b1;
					end else begin
						res_d.status = ST_NO_READY;
					end
				end else begin
					rd_en   = !exhausted;
					rd_addr = iss_q[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			func_q     <= FN_SUBMIT;
			sel_q      <= '0;
			seq_q      <= '0;
			cookie_q   <= '0;
			copy_ok_q  <= 1'b0;
			last_seq_q <= '0;
			iss_q      <= '0;
			pend_s1    <= 1'b0;
			chk_idx_s1 <= '0;
			res_q      <= '{status: ST_OK, slot: '0, seq: '0, cookie: '0};
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q    <= func;
						sel_q     <= slot_sel;
						seq_q     <= seq_tag;
						cookie_q  <= cookie_tag;
						copy_ok_q <= copy_ok;
						iss_q     <= '0;
						pend_s1   <= 1'b0;
						state_q   <= (func == FN_SUBMIT || func == FN_BEGIN_READ) ?
							S_SCAN : S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					res_q   <= res_d;
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (fin) begin
						res_q   <= res_d;
						state_q <= S_DONE;
						if (hit && func_q == FN_SUBMIT) begin
							last_seq_q <= nxt_seq;
						end
					end else begin
						pend_s1    <= rd_en;
						chk_idx_s1 <= iss_q[IDX_W-1:0];
						iss_q      <= iss_q + CNT_W'(rd_en);
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	`DSOT_ASSERT_NOW(a_wr_phase, wr_en, state_q == S_CHECK || state_q == S_SCAN)
	`DSOT_ASSERT_NEXT(a_take_idle, res_take, state_q == S_IDLE)
	`DSOT_ASSERT_NOW(a_ready_wr, evt.ready_inc || evt.ready_dec, wr_en)

endmodule
